/* hw/rtl/selective_receive_mailbox_assert.svh */
// assertion macros for the selective receive mailbox
`ifndef SELECTIVE_RECEIVE_MAILBOX_ASSERT_SVH
`define SELECTIVE_RECEIVE_MAILBOX_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define SRM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("srm assertion failed");

// condition in one cycle implies a property in the next
`define SRM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("srm assertion failed");

`else

`define SRM_ASSERT(label, clk, rst_n, prop)
`define SRM_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* hw/rtl/srm_pkg.sv */
// shared types, codes and constants of the selective receive mailbox
package srm_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int TYPE_COUNT          = 16;

	localparam int KIND_W      = 4;
	localparam int HANDLE_W    = 32;
	localparam int MASK_W      = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// request codes
	localparam logic [1:0] REQ_ENQUEUE = 2'd0;
	localparam logic [1:0] REQ_TAKE    = 2'd1;
	localparam logic [1:0] REQ_QUERY   = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_ENQUEUED  = 3'd0;
	localparam logic [2:0] STAT_DROP_IDLE = 3'd1;
	localparam logic [2:0] STAT_DROP_FULL = 3'd2;
	localparam logic [2:0] STAT_DELIVERED = 3'd3;
	localparam logic [2:0] STAT_NONE      = 3'd4;
	localparam logic [2:0] STAT_QUERY     = 3'd5;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_RUNNING    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPT_ALL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_MASK  = 2'd2;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [KIND_W-1:0]   msg_kind;
		logic [HANDLE_W-1:0] msg_handle;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [KIND_W-1:0]   out_kind;
		logic [HANDLE_W-1:0] out_handle;
		logic                has_acceptable;
	} rsp_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] handle;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic do_enq;
		logic res_none;
		logic res_hit;
		logic clr_idx;
		logic inc_idx;
		logic rd_scan;
		logic rd_shift;
		logic wr_shift;
		logic dec_fill;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_enq;
		logic is_take;
		logic empty;
		logic hit;
		logic idx_last;
		logic idx_penult;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/srm_ram.sv */
// generic simple dual port ram with registered read
module srm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/srm_ctrl.sv */
// sequencing state machine of the selective receive mailbox
`include "selective_receive_mailbox_assert.svh"

module srm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  srm_pkg::sts_t sts,
	output srm_pkg::cmd_t cmd
);

	import srm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (sts.is_enq || sts.empty) state_d = S_RESULT;
				else state_d = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (sts.hit) begin
					if (sts.is_take && !sts.idx_last) state_d = S_SHIFT_RD;
					else state_d = S_RESULT;
				end else if (sts.idx_last) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				if (sts.idx_penult) state_d = S_RESULT;
				else state_d = S_SHIFT_RD;
			end
			S_RESULT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready    = 1'b1;
				cmd.load_req = req_valid;
			end
			S_DISPATCH: begin
				if (sts.is_enq) cmd.do_enq = 1'b1;
				else if (sts.empty) cmd.res_none = 1'b1;
				else cmd.clr_idx = 1'b1;
			end
			S_SCAN_RD: begin
				cmd.rd_scan = 1'b1;
			end
			S_SCAN_CHK: begin
				if (sts.hit) begin
					cmd.res_hit  = 1'b1;
					cmd.dec_fill = sts.is_take && sts.idx_last;
				end else if (sts.idx_last) begin
					cmd.res_none = 1'b1;
				end else begin
					cmd.inc_idx = 1'b1;
				end
			end
			S_SHIFT_RD: begin
				cmd.rd_shift = 1'b1;
			end
			S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.inc_idx  = 1'b1;
				cmd.dec_fill = sts.idx_penult;
			end
			S_RESULT: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	`SRM_ASSERT(a_shift_only_on_take, clk, arst_n, ((state_q == S_SHIFT_RD) || (state_q == S_SHIFT_WR)) |-> sts.is_take)
	`SRM_ASSERT(a_dec_fill_nonempty, clk, arst_n, cmd.dec_fill |-> (!sts.empty && sts.is_take))

endmodule

/* hw/rtl/srm_dp.sv */
// datapath of the selective receive mailbox: store, counters, registers, result word
`include "selective_receive_mailbox_assert.svh"

module srm_dp #(
	parameter int QUEUE_DEPTH = srm_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  srm_pkg::req_t                      req,
	input  srm_pkg::cmd_t                      cmd,
	output srm_pkg::sts_t                      sts,
	input  logic                               cfg_valid,
	input  logic [srm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [srm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output srm_pkg::rsp_t                      rsp,
	output logic                               rsp_valid,
	input  logic                               rsp_ready
);

	import srm_pkg::*;

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int SLOT_W = $bits(slot_t);

	req_t              req_q;
	rsp_t              res_q;
	rsp_t              res_d;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic              running_q;
	logic              accept_all_q;
	logic [MASK_W-1:0] mask_q;

	logic              full;
	logic              enq_ok;
	logic [SUM_W-1:0]  fill_ext;
	logic [SUM_W-1:0]  idx_p1;
	logic [SUM_W-1:0]  idx_p2;
	logic              is_take;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [SLOT_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [SLOT_W-1:0] ram_rdata;
	slot_t             rd_slot;
	slot_t             enq_slot;
	logic              kind_ok;

	assign full     = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign enq_ok   = running_q && !full;
	assign fill_ext = SUM_W'(fill_q);
	assign idx_p1   = SUM_W'(idx_q) + SUM_W'(1);
	assign idx_p2   = SUM_W'(idx_q) + SUM_W'(2);
	assign is_take  = (req_q.req_type == REQ_TAKE);

	assign rd_slot         = slot_t'(ram_rdata);
	assign enq_slot.kind   = req_q.msg_kind;
	assign enq_slot.handle = req_q.msg_handle;

	// type filter on the word coming out of the store
	assign kind_ok = accept_all_q ||
		(({3'b000, rd_slot.kind} < 7'(TYPE_COUNT)) && mask_q[rd_slot.kind]);

	assign ram_we    = (cmd.do_enq && enq_ok) || cmd.wr_shift;
	assign ram_waddr = cmd.wr_shift ? idx_q : fill_q[IDX_W-1:0];
	assign ram_wdata = cmd.wr_shift ? ram_rdata : SLOT_W'(enq_slot);
	assign ram_re    = cmd.rd_scan || cmd.rd_shift;
	assign ram_raddr = cmd.rd_shift ? idx_p1[IDX_W-1:0] : idx_q;

	srm_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign sts.is_enq     = (req_q.req_type == REQ_ENQUEUE);
	assign sts.is_take    = is_take;
	assign sts.empty      = (fill_q == '0);
	assign sts.hit        = kind_ok;
	assign sts.idx_last   = (idx_p1 == fill_ext);
	assign sts.idx_penult = (idx_p2 == fill_ext);
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// result word for the request in hand
	always_comb begin
		res_d = '0;
		if (cmd.do_enq) begin
			res_d.status = !running_q ? STAT_DROP_IDLE :
				(full ? STAT_DROP_FULL : STAT_ENQUEUED);
		end else if (cmd.res_none) begin
			res_d.status = is_take ? STAT_NONE : STAT_QUERY;
		end else if (is_take) begin
			res_d.status     = STAT_DELIVERED;
			res_d.out_kind   = rd_slot.kind;
			res_d.out_handle = rd_slot.handle;
		end else begin
			res_d.status         = STAT_QUERY;
			res_d.has_acceptable = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			idx_q        <= '0;
			rsp_valid_q  <= 1'b0;
			running_q    <= 1'b1;
			accept_all_q <= 1'b1;
			mask_q       <= '0;
		end else begin
			if (cmd.do_enq && enq_ok) fill_q <= fill_q + CNT_W'(1);
			else if (cmd.dec_fill) fill_q <= fill_q - CNT_W'(1);

			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + IDX_W'(1);

			if (cmd.load_out) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_RUNNING:    running_q    <= cfg_data[0];
					CFG_ACCEPT_ALL: accept_all_q <= cfg_data[0];
					CFG_TYPE_MASK:  mask_q       <= cfg_data[MASK_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;

		if (cmd.do_enq || cmd.res_none || cmd.res_hit) res_q <= res_d;

		if (cmd.load_out) rsp_q <= res_q;
	end

	`SRM_ASSERT_NEXT(a_enq_grows_fill, clk, arst_n, cmd.do_enq && enq_ok, fill_q == $past(fill_q) + 1'b1)
	`SRM_ASSERT(a_scan_in_range, clk, arst_n, cmd.rd_scan |-> (SUM_W'(idx_q) < fill_ext))
	`SRM_ASSERT(a_shift_in_range, clk, arst_n, cmd.rd_shift |-> (idx_p1 < fill_ext))

endmodule

/* hw/rtl/selective_receive_mailbox.sv */
// top level of the selective receive mailbox
//
// bounded fifo mailbox with selective receive. a request word either enqueues a
// message (type and handle) at the tail, takes the oldest message whose type the
// filter accepts (or the head message in accept-all mode) and closes the gap, or
// asks whether an acceptable message waits. every request gives exactly one
// response word. messages are dropped with a status code while the block is not
// running or the store is full. messages live in a single ram with one write and
// one registered read port, so a take walks the store one slot at a time (read,
// then check) and then moves each later slot up one place (read, then write).
// one request is worked on at a time; the response register holds a finished word
// while the next request is accepted. the store needs no clearing after reset,
// only slots below the fill count are ever read. configuration writes are taken
// in any cycle (ready stays high) and are meant to happen while the block is idle.
module selective_receive_mailbox #(
	parameter int QUEUE_DEPTH = srm_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [srm_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                            req_valid,
	output logic                            req_ready,
	input  srm_pkg::req_t                   req,
	// response channel
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output srm_pkg::rsp_t                   rsp
);

	import srm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// registers are plain flops, a write never has to wait
	assign cfg_ready = 1'b1;

	// sequencer: dispatch, scan, compaction, response handoff
	srm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store, fill count, scan index, filter registers, response register
	srm_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

/* dv/tb_selective_receive_mailbox.sv */
// testbench of the selective receive mailbox: predictor, driver, receiver and checker
module tb_selective_receive_mailbox;
	timeunit 1ns;
	timeprecision 1ps;

	import srm_pkg::*;

	localparam int QDEPTH      = DEFAULT_QUEUE_DEPTH;
	localparam int CYCLE_LIMIT = 400000;
	// request code that the block answers like a query
	localparam logic [1:0] REQ_RSVD = 2'd3;
	// register index that has no register behind it
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	// receiver holds off this long once this many words have come out
	localparam int HOLD_LEN = 300;
	localparam int HOLD_AT0 = 120;
	localparam int HOLD_AT1 = 420;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;

	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	selective_receive_mailbox #(
		.QUEUE_DEPTH(QDEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// mailbox predictor: own copy of the store and of the registers
	// ------------------------------------------------------------------
	slot_t             mb_slots [QDEPTH];
	int                mb_fill       = 0;
	logic              mb_running    = 1'b1;
	logic              mb_accept_all = 1'b1;
	logic [MASK_W-1:0] mb_mask       = '0;

	// request words waiting for the driver, response words waiting for the dut
	req_t pending_reqs [$];
	rsp_t expected_rsps [$];

	int   mismatches = 0;
	int   words_out  = 0;
	logic req_acc    = 1'b0;

	function automatic rsp_t mailbox_predict(req_t r);
		rsp_t o;
		int   pos;
		o = '0;
		// oldest message whose type passes the filter, mb_fill if none
		pos = mb_fill;
		for (int i = 0; i < mb_fill; i++) begin
			if (mb_accept_all || (mb_slots[i].kind < TYPE_COUNT && mb_slots[i].kind < MASK_W
					&& mb_mask[mb_slots[i].kind])) begin
				pos = i;
				break;
			end
		end
		case (r.req_type)
			REQ_ENQUEUE: begin
				if (!mb_running) begin
					o.status = STAT_DROP_IDLE;
				end else if (mb_fill >= QDEPTH) begin
					o.status = STAT_DROP_FULL;
				end else begin
					mb_slots[mb_fill].kind   = r.msg_kind;
					mb_slots[mb_fill].handle = r.msg_handle;
					mb_fill++;
					o.status = STAT_ENQUEUED;
				end
			end
			REQ_TAKE: begin
				if (pos >= mb_fill) begin
					o.status = STAT_NONE;
				end else begin
					o.status     = STAT_DELIVERED;
					o.out_kind   = mb_slots[pos].kind;
					o.out_handle = mb_slots[pos].handle;
					// close the gap, order of the rest is kept
					for (int i = pos; i + 1 < mb_fill; i++)
						mb_slots[i] = mb_slots[i + 1];
					mb_fill--;
				end
			end
			default: begin
				// query, and the unused code as well
				o.status         = STAT_QUERY;
				o.has_acceptable = (pos < mb_fill);
			end
		endcase
		return o;
	endfunction

	task automatic check_field(string fname, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// monitor: samples every handshake at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			// response side first, its word belongs to an older request
			if (rsp_valid && rsp_ready) begin
				words_out++;
				if (expected_rsps.size() == 0) begin
					$error("response word with none expected: status %0d", rsp.status);
					mismatches++;
				end else begin
					want = expected_rsps[0];
					expected_rsps.delete(0);
					check_field("status", HANDLE_W'(want.status), HANDLE_W'(rsp.status));
					check_field("out_kind", HANDLE_W'(want.out_kind), HANDLE_W'(rsp.out_kind));
					check_field("out_handle", want.out_handle, rsp.out_handle);
					check_field("has_acceptable", HANDLE_W'(want.has_acceptable),
						HANDLE_W'(rsp.has_acceptable));
				end
			end
			// register writes, masked to their widths; unused index ignored
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RUNNING:    mb_running    = cfg_data[0];
					CFG_ACCEPT_ALL: mb_accept_all = cfg_data[0];
					CFG_TYPE_MASK:  mb_mask       = cfg_data[MASK_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				expected_rsps.insert(expected_rsps.size(), mailbox_predict(req));
		end
		// tells the driver at the next falling edge whether its word went in
		req_acc <= arst_n && req_valid && req_ready;
	end

	// ------------------------------------------------------------------
	// driver: bursts of random length with random gaps, fed from pending_reqs
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin
		logic v;
		req_t w;
		v = req_valid;
		w = req;
		if (!arst_n) begin
			v = 1'b0;
		end else if (!req_valid || req_acc) begin
			// previous word taken (or none offered), pick the next step
			v = 1'b0;
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0) begin
				v = 1'b1;
				w = pending_reqs[0];
				pending_reqs.delete(0);
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// a quarter of the bursts run back to back
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
		// otherwise hold valid and the word until taken
		req_valid <= v;
		req       <= w;
	end

	// ------------------------------------------------------------------
	// receiver: stall patterns that change now and then, plus two long holds
	// ------------------------------------------------------------------
	int hold_left = 0;
	int holds_done = 0;
	int pat_mode = 0;
	int pat_left = 0;
	int rx_tick = 0;

	always @(negedge clk) begin
		logic nxt;
		nxt = 1'b0;
		rx_tick <= rx_tick + 1;
		if (!arst_n) begin
			nxt = 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && words_out >= HOLD_AT0)
				|| (holds_done == 1 && words_out >= HOLD_AT1)) begin
			// long hold: the sender keeps offering, so the block fills and stalls
			hold_left  <= HOLD_LEN;
			holds_done <= holds_done + 1;
		end else begin
			if (pat_left == 0) begin
				pat_mode <= $urandom_range(0, 3);
				pat_left <= $urandom_range(20, 200);
			end else begin
				pat_left <= pat_left - 1;
			end
			case (pat_mode)
				0: nxt = 1'b1;                              // no stalls
				1: nxt = ($urandom_range(0, 99) < 60);      // random stalls
				2: nxt = (rx_tick % 3 != 0);                // one stall in three
				default: nxt = ($urandom_range(0, 99) < 15); // mostly stalled
			endcase
		end
		rsp_ready <= nxt;
	end

	// runaway guard
	int cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** selective_receive_mailbox: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic req_t mk_req(logic [1:0] t, logic [KIND_W-1:0] k, logic [HANDLE_W-1:0] h);
		req_t r;
		r.req_type   = t;
		r.msg_kind   = k;
		r.msg_handle = h;
		return r;
	endfunction

	function automatic req_t random_req(int enq_pct);
		req_t r;
		int   roll;
		roll       = $urandom_range(0, 99);
		r.msg_kind = KIND_W'($urandom_range(0, 15));
		case ($urandom_range(0, 7))
			0:       r.msg_handle = '0;
			1:       r.msg_handle = '1;
			default: r.msg_handle = $urandom;
		endcase
		if (roll < enq_pct)
			r.req_type = REQ_ENQUEUE;
		else if (roll >= 96)
			r.req_type = REQ_RSVD;
		else if ($urandom_range(0, 3) == 0)
			r.req_type = REQ_QUERY;
		else
			r.req_type = REQ_TAKE;
		return r;
	endfunction

	// append a request word for the driver
	function automatic void send_req(req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	// sender pauses until every word offered has been answered
	task automatic drain();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
	endtask

	// register write, only called while the block is idle
	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic              run_bit;
		logic              all_bit;
		logic [MASK_W-1:0] mask_val;
		int                enq_pct;

		// reset once, released on a falling edge
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings (running, accept all)
		// empty store: take finds nothing, query and the unused code say no
		send_req(mk_req(REQ_TAKE, 4'd0, 32'h0));
		send_req(mk_req(REQ_QUERY, 4'd0, 32'h0));
		send_req(mk_req(REQ_RSVD, 4'd15, 32'hFFFF_FFFF));
		// field extremes, then the unused code sees a waiting message
		send_req(mk_req(REQ_ENQUEUE, 4'd0, 32'h0000_0000));
		send_req(mk_req(REQ_ENQUEUE, 4'd15, 32'hFFFF_FFFF));
		send_req(mk_req(REQ_ENQUEUE, 4'd7, 32'hA5A5_A5A5));
		send_req(mk_req(REQ_ENQUEUE, 4'd3, 32'h5A5A_5A5A));
		send_req(mk_req(REQ_RSVD, 4'd0, 32'h0));
		send_req(mk_req(REQ_TAKE, 4'd0, 32'h0));
		drain();

		// selective: types 3 and 7 only, store holds 15, 7, 3
		cfg_write(CFG_ACCEPT_ALL, 16'hFFFE);
		cfg_write(CFG_TYPE_MASK, 16'h0088);
		send_req(mk_req(REQ_TAKE, 4'd0, 32'h0));  // from the middle
		send_req(mk_req(REQ_QUERY, 4'd0, 32'h0));
		send_req(mk_req(REQ_TAKE, 4'd0, 32'h0));  // from the tail
		send_req(mk_req(REQ_TAKE, 4'd0, 32'h0));  // only type 15 left
		send_req(mk_req(REQ_QUERY, 4'd0, 32'h0));
		drain();

		// stopped: enqueue dropped, take still works; unused index ignored
		cfg_write(CFG_RUNNING, 16'hFFFE);
		cfg_write(CFG_UNUSED, 16'hFFFF);
		send_req(mk_req(REQ_ENQUEUE, 4'd1, 32'h1234_5678));
		send_req(mk_req(REQ_TAKE, 4'd0, 32'h0));
		drain();
		cfg_write(CFG_ACCEPT_ALL, 16'h0001);
		send_req(mk_req(REQ_TAKE, 4'd0, 32'h0));
		drain();

		// random phases, each with its own register settings
		for (int p = 0; p < 8; p++) begin
			mask_val = MASK_W'($urandom);
			case (p)
				0: begin run_bit = 1'b1; all_bit = 1'b1; enq_pct = 85; end
				1: begin run_bit = 1'b1; all_bit = 1'b0; mask_val = '1; enq_pct = 50; end
				2: begin run_bit = 1'b1; all_bit = 1'b0; mask_val = '0; enq_pct = 45; end
				3: begin run_bit = 1'b1; all_bit = 1'b0; enq_pct = 25; end
				4: begin run_bit = 1'b0; all_bit = 1'b0; enq_pct = 50; end
				5: begin
					run_bit  = 1'b1;
					all_bit  = 1'b0;
					mask_val = 16'h1 << $urandom_range(0, 15);
					enq_pct  = 65;
				end
				6: begin run_bit = 1'b1; all_bit = 1'b1; enq_pct = 55; end
				default: begin run_bit = 1'b1; all_bit = 1'b0; enq_pct = 70; end
			endcase
			// upper bits of the one-bit registers are random and must be ignored
			cfg_write(CFG_RUNNING, {15'($urandom), run_bit});
			cfg_write(CFG_ACCEPT_ALL, {15'($urandom), all_bit});
			cfg_write(CFG_TYPE_MASK, mask_val);
			repeat (75) send_req(random_req(enq_pct));
			drain();
		end

		// let any stray word show up
		repeat (100) @(posedge clk);
		if (expected_rsps.size() != 0) begin
			$error("%0d response words never arrived", expected_rsps.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("** selective_receive_mailbox: PASSED **");
		else
			$display("** selective_receive_mailbox: FAILED **");
		$finish;
	end

endmodule

/* selective_receive_mailbox.f */
+incdir+hw/rtl
hw/rtl/srm_pkg.sv
hw/rtl/srm_ram.sv
hw/rtl/srm_ctrl.sv
hw/rtl/srm_dp.sv
hw/rtl/selective_receive_mailbox.sv
dv/tb_selective_receive_mailbox.sv
